### design/zpg_pkg.sv
package zpg_pkg;

	// Field and register widths
	localparam int unsigned DIM_W   = 13;
	localparam int unsigned COEF_W  = 8;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned FRAME_W = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CIDX_W  = 3;

	// Dimensions above this are clamped before use
	localparam int unsigned MAX_DIM = 4096;

	// Register values after reset
	localparam logic [DIM_W-1:0]  RST_WIDTH   = 13'd640;
	localparam logic [DIM_W-1:0]  RST_HEIGHT  = 13'd480;
	localparam logic [COEF_W-1:0] RST_COEF_T  = 8'd10;
	localparam logic [COEF_W-1:0] RST_COEF_T2 = 8'd0;
	localparam logic [COEF_W-1:0] RST_COEF_X2 = 8'd10;
	localparam logic [COEF_W-1:0] RST_COEF_Y2 = 8'd10;

	// Divider shapes: y term is 32-bit signed over height, x scale is 0xffff over width
	localparam int unsigned YDIV_W      = 32;
	localparam int unsigned SCALE_W     = 16;
	localparam logic [SCALE_W-1:0] SCALE_NUM = 16'hffff;
	localparam int unsigned SQ_W        = 24;

	// Codes on the action field
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	// Register indexes
	typedef enum logic [CIDX_W-1:0] {
		REG_WIDTH   = 3'd0,
		REG_HEIGHT  = 3'd1,
		REG_COEF_T  = 3'd2,
		REG_COEF_T2 = 3'd3,
		REG_COEF_X2 = 3'd4,
		REG_COEF_Y2 = 3'd5
	} zpg_reg_t;

	// Request into the wave table
	typedef struct packed {
		logic              we;
		logic              re;
		logic [BYTE_W-1:0] addr;
		logic [BYTE_W-1:0] wdata;
	} zpg_mem_req_t;

	// Clamp a dimension register
	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		r = d;
		if (32'(d) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end
		return r;
	endfunction

endpackage

### design/zpg_div.sv
// Pipelined restoring divider, one quotient bit per stage
module zpg_div import zpg_pkg::*; #(
	parameter int unsigned DVD_W = YDIV_W,
	parameter int unsigned DVS_W = DIM_W,
	parameter int unsigned Q_W   = BYTE_W
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [Q_W-1:0]   quotient
);

	logic [DVS_W-1:0] rem_q [DVD_W];
	logic [DVD_W-1:0] dvd_q [DVD_W];
	logic [Q_W-1:0]   quo_q [DVD_W];

	logic [DVS_W-1:0] rem_in [DVD_W];
	logic [DVD_W-1:0] dvd_in [DVD_W];
	logic [Q_W-1:0]   quo_in [DVD_W];

	for (genvar s = 0; s < DVD_W; s++) begin : g_stage
		logic [DVS_W:0] trial;
		logic           ge;

		// Previous partial remainder, or a fresh start at the first stage
		if (s == 0) begin : g_first
			assign rem_in[s] = '0;
			assign dvd_in[s] = dividend;
			assign quo_in[s] = '0;
		end else begin : g_next
			assign rem_in[s] = rem_q[s-1];
			assign dvd_in[s] = dvd_q[s-1];
			assign quo_in[s] = quo_q[s-1];
		end

		// Shift in the next dividend bit and try the subtract
		assign trial = {rem_in[s], dvd_in[s][DVD_W-1]};
		assign ge    = (trial >= {1'b0, divisor});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[s] <= ge ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];
				dvd_q[s] <= {dvd_in[s][DVD_W-2:0], 1'b0};
				quo_q[s] <= {quo_in[s][Q_W-2:0], ge};
			end
		end
	end

	assign quotient = quo_q[DVD_W-1];

endmodule

### design/zpg_wave_mem.sv
// 256 x 8 wave table, one write and one registered read per cycle while en is high
module zpg_wave_mem import zpg_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  zpg_mem_req_t      req,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem_q [2**BYTE_W];
	logic [BYTE_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (en && req.we) begin
			mem_q[req.addr] <= req.wdata;
		end
	end

	// Read port, data held while stalled
	always_ff @(posedge clk) begin
		if (en && req.re) begin
			rdata_q <= mem_q[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/zone_plate_pixel_generator.sv
// Zone-plate pixel generator: one item per clock unless stalled, loads and pixels in order.
// A pixel passes stages 1 to 3, the 32-stage divider for the vertical term,
// the last stage and the registered table read before it shows on the output.
// Throughput: one item per cycle while the output is not stalled.
// Reset clears the pipeline valids and the output valid, and returns the
// registers to their defaults; the wave table is left as it was.
module zone_plate_pixel_generator import zpg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [DIM_W-1:0]   cfg_data,
	// item channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               action,
	input  logic [BYTE_W-1:0]  table_index,
	input  logic [BYTE_W-1:0]  table_value,
	input  logic [FRAME_W-1:0] frame_count,
	input  logic [POS_W-1:0]   column,
	input  logic [POS_W-1:0]   row,
	// pixel channel
	output logic               pixel_valid,
	input  logic               pixel_stall,
	output logic [BYTE_W-1:0]  pixel_value
);

	localparam int unsigned NSIDE = YDIV_W;

	// Sideband carried alongside the vertical divider
	typedef struct packed {
		logic              act;
		logic [BYTE_W-1:0] idx;
		logic [BYTE_W-1:0] val;
		logic              neg;
		logic [BYTE_W-1:0] pt;
		logic [SQ_W-1:0]   vx;
	} zpg_side_t;

	logic [DIM_W-1:0]  width_q, height_q;
	logic [COEF_W-1:0] coef_t_q, coef_t2_q, coef_x2_q, coef_y2_q;
	logic [DIM_W-1:0]  w_sat, h_sat;
	logic              adv;
	logic              out_vld_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= RST_WIDTH;
			height_q  <= RST_HEIGHT;
			coef_t_q  <= RST_COEF_T;
			coef_t2_q <= RST_COEF_T2;
			coef_x2_q <= RST_COEF_X2;
			coef_y2_q <= RST_COEF_Y2;
		end else if (cfg_we) begin
			case (zpg_reg_t'(cfg_index))
				REG_WIDTH:   width_q   <= cfg_data;
				REG_HEIGHT:  height_q  <= cfg_data;
				REG_COEF_T:  coef_t_q  <= cfg_data[COEF_W-1:0];
				REG_COEF_T2: coef_t2_q <= cfg_data[COEF_W-1:0];
				REG_COEF_X2: coef_x2_q <= cfg_data[COEF_W-1:0];
				REG_COEF_Y2: coef_y2_q <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	assign w_sat = sat_dim(width_q);
	assign h_sat = sat_dim(height_q);

	// Whole pipeline moves unless a finished pixel is held at the output
	assign adv        = !out_vld_q || !pixel_stall;
	assign item_stall = !adv;

	// Stage 1: capture, centre the coordinates
	logic                     vld_s1, act_s1;
	logic [BYTE_W-1:0]        idx_s1, val_s1;
	logic [FRAME_W-1:0]       t_s1;
	logic signed [DIM_W-1:0]  x_s1, y_s1;
	logic signed [DIM_W-1:0]  x_w, y_w;

	assign x_w = $signed({1'b0, column}) - $signed({1'b0, w_sat[DIM_W-1:1]});
	assign y_w = $signed({1'b0, row}) - $signed({1'b0, h_sat[DIM_W-1:1]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1 <= action;
			idx_s1 <= table_index;
			val_s1 <= table_value;
			t_s1   <= frame_count;
			x_s1   <= x_w;
			y_s1   <= y_w;
		end
	end

	// Stage 2: squares and the linear time term
	logic                    vld_s2, act_s2;
	logic [BYTE_W-1:0]       idx_s2, val_s2;
	logic [SQ_W-1:0]         xx_s2, yy_s2;
	logic [BYTE_W-1:0]       lin_s2;
	logic [BYTE_W:0]         tt_s2;
	logic signed [2*DIM_W-1:0] xsq_w, ysq_w;
	logic [BYTE_W-1:0]       lin_w;
	logic [BYTE_W:0]         tt_w;

	assign xsq_w = (2*DIM_W)'(x_s1) * (2*DIM_W)'(x_s1);
	assign ysq_w = (2*DIM_W)'(y_s1) * (2*DIM_W)'(y_s1);
	assign lin_w = coef_t_q * t_s1[BYTE_W-1:0];
	assign tt_w  = t_s1[BYTE_W:0] * t_s1[BYTE_W:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2 <= act_s1;
			idx_s2 <= idx_s1;
			val_s2 <= val_s1;
			xx_s2  <= xsq_w[SQ_W-1:0];
			yy_s2  <= ysq_w[SQ_W-1:0];
			lin_s2 <= lin_w;
			tt_s2  <= tt_w;
		end
	end

	// Stage 3: coefficient products, time phase complete
	logic                vld_s3, act_s3;
	logic [BYTE_W-1:0]   idx_s3, val_s3;
	logic [YDIV_W-1:0]   vy_s3;
	logic [SQ_W-1:0]     vx_s3;
	logic [BYTE_W-1:0]   pt_s3;
	logic [YDIV_W-1:0]   vy_w;
	logic [SQ_W-1:0]     vx_w;
	logic [BYTE_W:0]     tq_w;

	assign vy_w = YDIV_W'(coef_y2_q) * YDIV_W'(yy_s2);
	assign vx_w = SQ_W'(coef_x2_q) * xx_s2;
	assign tq_w = (BYTE_W+1)'(coef_t2_q) * tt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s3 <= act_s2;
			idx_s3 <= idx_s2;
			val_s3 <= val_s2;
			vy_s3  <= vy_w;
			vx_s3  <= vx_w;
			pt_s3  <= lin_s2 + tq_w[BYTE_W:1];
		end
	end

	// Vertical term: magnitude into the divider, sign rides alongside
	logic              neg_w;
	logic [YDIV_W-1:0] mag_w;
	logic [BYTE_W-1:0] yq;

	assign neg_w = vy_s3[YDIV_W-1];
	assign mag_w = neg_w ? -vy_s3 : vy_s3;

	zpg_div #(
		.DVD_W (YDIV_W),
		.DVS_W (DIM_W),
		.Q_W   (BYTE_W)
	) u_ydiv (
		.clk      (clk),
		.en       (adv),
		.dividend (mag_w),
		.divisor  (h_sat),
		.quotient (yq)
	);

	// Horizontal scale depends on width alone, so it runs free
	logic [SCALE_W-1:0] scale;

	zpg_div #(
		.DVD_W (SCALE_W),
		.DVS_W (DIM_W),
		.Q_W   (SCALE_W)
	) u_sdiv (
		.clk      (clk),
		.en       (1'b1),
		.dividend (SCALE_NUM),
		.divisor  (w_sat),
		.quotient (scale)
	);

	// Delay line matching the divider depth
	logic      vld_d_q  [NSIDE];
	zpg_side_t side_d_q [NSIDE];
	zpg_side_t side_in;

	assign side_in = '{act: act_s3, idx: idx_s3, val: val_s3, neg: neg_w,
		pt: pt_s3, vx: vx_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSIDE; i++) begin
				vld_d_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_d_q[0] <= vld_s3;
			for (int i = 1; i < NSIDE; i++) begin
				vld_d_q[i] <= vld_d_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d_q[0] <= side_in;
			for (int i = 1; i < NSIDE; i++) begin
				side_d_q[i] <= side_d_q[i-1];
			end
		end
	end

	// Last stage: signed vertical term, horizontal product
	logic              vld_s36, act_s36;
	logic [BYTE_W-1:0] idx_s36, val_s36, ys_s36, xt_s36;
	zpg_side_t         side_o;
	logic [BYTE_W-1:0] yt_w;
	logic [SCALE_W-1:0] scale_eff;
	logic [SQ_W-1:0]   xm_w;

	assign side_o    = side_d_q[NSIDE-1];
	assign yt_w      = (h_sat == '0) ? '0 : (side_o.neg ? -yq : yq);
	assign scale_eff = (w_sat == '0) ? '0 : scale;
	assign xm_w      = side_o.vx * SQ_W'(scale_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s36 <= 1'b0;
		end else if (adv) begin
			vld_s36 <= vld_d_q[NSIDE-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s36 <= side_o.act;
			idx_s36 <= side_o.idx;
			val_s36 <= side_o.val;
			ys_s36  <= side_o.pt + yt_w;
			xt_s36  <= xm_w[SQ_W-1:SQ_W-BYTE_W];
		end
	end

	// Table access: loads write, pixels read, both in item order
	zpg_mem_req_t mem_req;

	assign mem_req.we    = vld_s36 && (act_s36 == ACT_LOAD);
	assign mem_req.re    = vld_s36 && (act_s36 == ACT_PIXEL);
	assign mem_req.addr  = (act_s36 == ACT_PIXEL) ? (ys_s36 + xt_s36) : idx_s36;
	assign mem_req.wdata = val_s36;

	zpg_wave_mem u_mem (
		.clk   (clk),
		.en    (adv),
		.req   (mem_req),
		.rdata (pixel_value)
	);

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= mem_req.re;
		end
	end

	assign pixel_valid = out_vld_q;

endmodule
